### design/cprm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cprm_pkg
// Shared types and constants for the capture-period rpm meter.
// ----------------------------------------------------------------------------
package cprm_pkg;

  // Field widths fixed by the stream format
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned OVF_W     = 16;
  localparam int unsigned CAPVAL_W  = 16;

  // Shared subtractor: two guard bits above a word
  localparam int unsigned SUB_W     = WORD_W + 2;

  // Restoring division: one quotient bit per step
  localparam int unsigned DIV_STEPS = WORD_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  localparam logic [WORD_W-1:0] RPM_NUM_RESET = 32'd22500000;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [OVF_W-1:0]  ovf_t;
  typedef logic [SUB_W-1:0]  sub_t;
  typedef logic [CNT_W-1:0]  cnt_t;

endpackage

### design/capture_period_rpm_meter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capture_period_rpm_meter_top
// Capture-period tachometer: timestamps capture events, forms the period and
// divides the rpm numerator by it on one shared subtractor.
// ----------------------------------------------------------------------------
// Flow: a capture with a non-zero period runs from accept through the 32
//   restoring-division steps to the hand-off, which holds until the output
//   register is free; a zero period goes from accept straight to hand-off.
//   An item without capture finishes in its accept cycle. No new item is
//   accepted before the hand-off; division runs on the one shared subtractor.
// Reset: rst_ni (asynchronous, active low) clears the overflow count, the
//   last timestamp and the output valid, and loads the numerator to 22500000.
module capture_period_rpm_meter_top #(
  parameter int unsigned CAPTURE_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // Configuration: rpm_numerator
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,

  // Timer event stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] capture_value
  input  logic [1:0]  s_axis_tuser_i,   // [0] overflow_event, [1] capture_event

  // Result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // [31:0] period_ticks, [63:32] rpm_value
  output logic [0:0]  m_axis_tuser_o    // [0] zero_period
);

  // Sequencer codes
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]    state_q, state_d;
  cprm_pkg::word_t num_q;
  cprm_pkg::ovf_t  ovf_q, ovf_d;
  cprm_pkg::word_t last_q, last_d;
  cprm_pkg::word_t per_q, per_d;      // period, also the divisor
  cprm_pkg::word_t quo_q, quo_d;      // dividend shifting out, quotient in
  cprm_pkg::word_t rem_q, rem_d;
  logic            zero_q, zero_d;
  cprm_pkg::cnt_t  cnt_q, cnt_d;

  logic            m_valid_q, m_valid_d;
  cprm_pkg::word_t m_per_q, m_per_d;
  cprm_pkg::word_t m_rpm_q, m_rpm_d;
  logic            m_zero_q, m_zero_d;

  logic            in_fire;
  logic            out_free;
  cprm_pkg::ovf_t  ovf_next;
  cprm_pkg::word_t stamp;
  cprm_pkg::sub_t  trial;
  cprm_pkg::sub_t  sub_a, sub_b, sub_y;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free        = ~m_valid_q | m_axis_tready_i;

  // Overflow in the same transaction counts before the capture
  assign ovf_next = ovf_q + cprm_pkg::ovf_t'(s_axis_tuser_i[0]);

  // Timestamp: overflow count over capture bits, mod 2^32; 32+ bits: value only
  generate
    if (CAPTURE_WIDTH >= 32) begin : g_stamp_wide
      assign stamp = {{(cprm_pkg::WORD_W - cprm_pkg::CAPVAL_W){1'b0}}, s_axis_tdata_i};
    end else begin : g_stamp_split
      localparam logic [63:0] LowMask = (64'd1 << CAPTURE_WIDTH) - 64'd1;
      logic [63:0] stamp_wide;
      assign stamp_wide = ({48'd0, ovf_next} << CAPTURE_WIDTH)
                        | ({48'd0, s_axis_tdata_i} & LowMask);
      assign stamp      = stamp_wide[31:0];
    end
  endgenerate

  // Trial remainder of one restoring step
  assign trial = {1'b0, rem_q, quo_q[cprm_pkg::WORD_W-1]};

  // The one subtractor: period on accept, trial subtract while dividing
  always_comb begin
    if (state_q == ST_DIV) begin
      sub_a = trial;
      sub_b = {2'b00, per_q};
    end else begin
      sub_a = {2'b00, stamp};
      sub_b = {2'b00, last_q};
    end
  end
  assign sub_y = sub_a - sub_b;

  always_comb begin
    state_d   = state_q;
    ovf_d     = ovf_q;
    last_d    = last_q;
    per_d     = per_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    zero_d    = zero_q;
    cnt_d     = cnt_q;
    m_valid_d = m_valid_q & ~m_axis_tready_i;
    m_per_d   = m_per_q;
    m_rpm_d   = m_rpm_q;
    m_zero_d  = m_zero_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          ovf_d = ovf_next;
          if (s_axis_tuser_i[1]) begin
            // Store the stamp and set up the divider, or skip it on zero period
            last_d = stamp;
            per_d  = sub_y[31:0];
            rem_d  = '0;
            cnt_d  = cprm_pkg::cnt_t'(cprm_pkg::DIV_STEPS - 1);
            if (sub_y[31:0] == '0) begin
              quo_d   = '0;
              zero_d  = 1'b1;
              state_d = ST_DONE;
            end else begin
              quo_d   = num_q;
              zero_d  = 1'b0;
              state_d = ST_DIV;
            end
          end
        end
      end
      ST_DIV: begin
        // Keep the difference when no borrow, else restore
        if (!sub_y[cprm_pkg::SUB_W-1]) begin
          rem_d = sub_y[31:0];
          quo_d = {quo_q[30:0], 1'b1};
        end else begin
          rem_d = trial[31:0];
          quo_d = {quo_q[30:0], 1'b0};
        end
        cnt_d = cnt_q - cprm_pkg::cnt_t'(1);
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hold until the output register is free
        if (out_free) begin
          m_valid_d = 1'b1;
          m_per_d   = per_q;
          m_rpm_d   = quo_q;
          m_zero_d  = zero_q;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      num_q     <= cprm_pkg::RPM_NUM_RESET;
      ovf_q     <= '0;
      last_q    <= '0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ovf_q     <= ovf_d;
      last_q    <= last_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        num_q <= cfg_wdata_i;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    per_q    <= per_d;
    quo_q    <= quo_d;
    rem_q    <= rem_d;
    zero_q   <= zero_d;
    m_per_q  <= m_per_d;
    m_rpm_q  <= m_rpm_d;
    m_zero_q <= m_zero_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {m_rpm_q, m_per_q};
  assign m_axis_tuser_o  = m_zero_q;

`ifndef ASSERT_OFF
  // A zero-period result carries zero period and zero rpm
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_zero_q) |-> (m_per_q == '0 && m_rpm_q == '0))
    else $error("zero-period result with non-zero fields");

  // A divided result never has a zero period
  a_nonzero_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_zero_q) |-> (m_per_q != '0))
    else $error("divided result with zero period");

  // The last division step hands over to the output stage
  a_div_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && cnt_q == '0) |=> (state_q == ST_DONE))
    else $error("division did not end after its last step");

  // A finished result reaches the output register once it is free
  a_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> (m_valid_q && state_q == ST_IDLE))
    else $error("result not handed to output register");
`endif

endmodule
